[rtl/hdc_pkg.sv]
package hdc_pkg;

    localparam int MEM_WORDS_DEF = 65536;

    localparam logic [3:0] PC_IDX = 4'd15;
    localparam logic [3:0] SP_IDX = 4'd14;

    // console commands
    typedef enum logic [2:0] {
        CMD_STEP   = 3'd0,
        CMD_WR_MEM = 3'd1,
        CMD_WR_REG = 3'd2,
        CMD_RD_MEM = 3'd3,
        CMD_RD_REG = 3'd4,
        CMD_NOP    = 3'd5
    } cmd_t;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_HALT     = 2'd1;
    localparam logic [1:0] STAT_INVALID  = 2'd2;
    localparam logic [1:0] STAT_NOT_IMPL = 2'd3;

    // instruction classes by highest non-zero hex digit
    typedef enum logic [3:0] {
        CL_MEM, CL_IMM, CL_SHIFT, CL_REG, CL_STUB, CL_IO, CL_MISC, CL_NONE, CL_HALT
    } cls_t;

    // memory-reference ops
    localparam logic [3:0] OPM_LOAD  = 4'd1;
    localparam logic [3:0] OPM_STORE = 4'd2;
    localparam logic [3:0] OPM_ADD   = 4'd3;
    localparam logic [3:0] OPM_SUB   = 4'd4;
    localparam logic [3:0] OPM_JUMP  = 4'd5;
    localparam logic [3:0] OPM_CALL  = 4'd6;
    // immediate ops
    localparam logic [3:0] OPI_MOV  = 4'd1;
    localparam logic [3:0] OPI_MOVS = 4'd2;
    localparam logic [3:0] OPI_ADD  = 4'd3;
    localparam logic [3:0] OPI_SUB  = 4'd4;
    localparam logic [3:0] OPI_OR   = 4'd5;
    localparam logic [3:0] OPI_AND  = 4'd6;
    localparam logic [3:0] OPI_XOR  = 4'd7;
    // shift ops
    localparam logic [3:0] OPS_SLL = 4'd1;
    localparam logic [3:0] OPS_SRL = 4'd2;
    localparam logic [3:0] OPS_SLA = 4'd3;
    localparam logic [3:0] OPS_SRA = 4'd4;
    localparam logic [3:0] OPS_ROL = 4'd5;
    localparam logic [3:0] OPS_ROR = 4'd6;
    // register ops
    localparam logic [3:0] OPR_MOV  = 4'd1;
    localparam logic [3:0] OPR_ADD  = 4'd2;
    localparam logic [3:0] OPR_SUB  = 4'd3;
    localparam logic [3:0] OPR_OR   = 4'd4;
    localparam logic [3:0] OPR_AND  = 4'd5;
    localparam logic [3:0] OPR_XOR  = 4'd6;
    localparam logic [3:0] OPR_SKGT = 4'd7;
    localparam logic [3:0] OPR_SKGE = 4'd8;
    localparam logic [3:0] OPR_SKEQ = 4'd9;
    localparam logic [3:0] OPR_SKLE = 4'd10;
    localparam logic [3:0] OPR_SKLT = 4'd11;
    localparam logic [3:0] OPR_OVF1 = 4'd12;
    localparam logic [3:0] OPR_OVF2 = 4'd13;
    // I/O ops
    localparam logic [3:0] OPO_PUTC = 4'd1;
    localparam logic [3:0] OPO_GETC = 4'd2;
    localparam logic [3:0] OPO_DUMP = 4'd3;
    // misc ops
    localparam logic [3:0] OPX_NOP = 4'd1;
    localparam logic [3:0] OPX_RET = 4'd2;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] mem_address;
        logic [3:0]  reg_number;
        logic [31:0] write_data;
        logic [7:0]  char_in;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [31:0] program_counter;
        logic        char_out_valid;
        logic [7:0]  char_out;
        logic        char_in_taken;
        logic        dump_valid;
        logic [3:0]  dump_reg;
    } result_t;

    function automatic cls_t classify(input logic [31:0] ins);
        cls_t c;
        if (ins == 32'd0)              c = CL_HALT;
        else if (ins[31:28] != 4'd0)   c = CL_MEM;
        else if (ins[27:24] != 4'd0)   c = CL_IMM;
        else if (ins[23:20] != 4'd0)   c = CL_SHIFT;
        else if (ins[19:16] != 4'd0)   c = CL_REG;
        else if (ins[15:12] != 4'd0)   c = CL_STUB;
        else if (ins[11:8] != 4'd0)    c = CL_IO;
        else if (ins[7:4] != 4'd0)     c = CL_MISC;
        else                           c = CL_NONE;
        return c;
    endfunction

endpackage

[rtl/hex_digit_cpu_step_top.sv]
// A step passes fetch (S_IDLE), decode with data read (S_DEC) and execute with
// write-back (S_EXEC); a memory read passes S_RDMEM, other console words end in
// S_IDLE; each result then passes an output register. Steps do not overlap; fetch,
// data access and write-back share main memory (one write, one registered read
// port); a two-word input queue decouples the sides. Reset: aresetn (synchronous,
// active low) clears registers, then a sweep zeroes main memory with s_tready low.
module hex_digit_cpu_step_top #(
    parameter int MEM_WORDS = hdc_pkg::MEM_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // mem_address, reg_number, write_data, char_in
    input  logic [2:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data, program_counter, char_out_valid, char_out, char_in_taken,
    // dump_valid, dump_reg
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser   // status
);

    logic             ready_en, q_valid, q_pop, out_free, res_valid;
    hdc_pkg::item_t   q_item;
    hdc_pkg::result_t res, out_reg;
    logic             out_valid_reg;

    hdc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (ready_en),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_cmd   (s_tuser),
        .s_data  (s_tdata[59:0]),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    hdc_core #(.MEM_WORDS(MEM_WORDS)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ready_en  (ready_en),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || m_tready;

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.dump_reg, out_reg.dump_valid, out_reg.char_in_taken,
                       out_reg.char_out, out_reg.char_out_valid,
                       out_reg.program_counter, out_reg.read_data};

endmodule

[rtl/hdc_front.sv]
module hdc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_cmd,
    input  logic [59:0]       s_data,
    output logic              q_valid,
    output hdc_pkg::item_t    q_item,
    input  logic              q_pop
);

    hdc_pkg::item_t buf_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    hdc_pkg::item_t in_item;
    logic           push;

    // classify the command; unknown codes become a no-op
    always_comb begin
        in_item.mem_address = s_data[15:0];
        in_item.reg_number  = s_data[19:16];
        in_item.write_data  = s_data[51:20];
        in_item.char_in     = s_data[59:52];
        case (s_cmd)
            3'd0:    in_item.cmd = hdc_pkg::CMD_STEP;
            3'd1:    in_item.cmd = hdc_pkg::CMD_WR_MEM;
            3'd2:    in_item.cmd = hdc_pkg::CMD_WR_REG;
            3'd3:    in_item.cmd = hdc_pkg::CMD_RD_MEM;
            3'd4:    in_item.cmd = hdc_pkg::CMD_RD_REG;
            default: in_item.cmd = hdc_pkg::CMD_NOP;
        endcase
    end

    assign s_ready = enable && (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];

    // two-word queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                buf_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[rtl/hdc_core.sv]
module hdc_core #(
    parameter int MEM_WORDS = hdc_pkg::MEM_WORDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    output logic              ready_en,
    input  logic              q_valid,
    input  hdc_pkg::item_t    q_item,
    output logic              q_pop,
    input  logic              out_free,
    output logic              res_valid,
    output hdc_pkg::result_t  res
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DEC, S_EXEC, S_RDMEM} state_t;

    state_t          state_reg, state_next;
    logic [31:0]     regs_reg [16];
    logic [31:0]     mem [MEM_WORDS];
    logic [31:0]     rdata_reg;
    logic [AW-1:0]   clr_reg;
    hdc_pkg::item_t  cur_reg, cur_next;
    logic [31:0]     ins_reg, ins_next;
    hdc_pkg::cls_t   cls_reg, cls_next, dcls;
    logic [31:0]     ea_reg, ea_next;
    logic [31:0]     a_reg, a_next;

    logic [3:0]      rp_idx;
    logic [31:0]     rp_val, pc, sp;
    logic            rd_en, mem_we;
    logic [31:0]     raddr, waddr, mem_wdata, addr_ext;
    logic            rf_we, sp_set, pc_set;
    logic [3:0]      rf_idx;
    logic [31:0]     rf_val, sp_val, pc_val;

    // execute-stage temporaries
    logic [3:0]      op, didx;
    logic [31:0]     b, nv, v, sv, base_pc;
    logic [4:0]      n;
    logic [63:0]     rl, rr;
    logic            wr, jmp, skip, bad;
    logic [31:0]     jtgt;
    logic [1:0]      stat;

    assign pc       = regs_reg[hdc_pkg::PC_IDX];
    assign sp       = regs_reg[hdc_pkg::SP_IDX];
    assign rp_val   = regs_reg[rp_idx];
    assign ready_en = (state_reg != S_CLEAR);
    assign addr_ext = {16'd0, q_item.mem_address};
    assign dcls     = hdc_pkg::classify(rdata_reg);

    // register read port select
    always_comb begin
        case (state_reg)
            S_DEC: begin
                case (dcls)
                    hdc_pkg::CL_MEM: rp_idx = rdata_reg[27:24];
                    default:         rp_idx = rdata_reg[3:0];
                endcase
            end
            S_EXEC: begin
                case (cls_reg)
                    hdc_pkg::CL_MEM,
                    hdc_pkg::CL_IMM:   rp_idx = ins_reg[23:20];
                    hdc_pkg::CL_SHIFT: rp_idx = ins_reg[19:16];
                    hdc_pkg::CL_REG:   rp_idx = ins_reg[11:8];
                    default:           rp_idx = ins_reg[3:0];
                endcase
            end
            default: rp_idx = q_item.reg_number;
        endcase
    end

    // instruction execution
    always_comb begin
        b    = rp_val;
        didx = rp_idx;
        nv   = 32'd0;
        wr   = 1'b0;
        jmp  = 1'b0;
        jtgt = 32'd0;
        skip = 1'b0;
        bad  = 1'b0;
        stat = hdc_pkg::STAT_OK;
        op   = 4'd0;
        v    = {12'd0, ins_reg[19:0]};
        sv   = {{12{ins_reg[19]}}, ins_reg[19:0]};
        n    = ins_reg[4:0];
        rl   = {b, b} << n;
        rr   = {b, b} >> n;
        case (cls_reg)
            hdc_pkg::CL_HALT: begin
                stat = hdc_pkg::STAT_HALT;
            end
            hdc_pkg::CL_NONE: begin
                stat = hdc_pkg::STAT_NOT_IMPL;
            end
            hdc_pkg::CL_MEM: begin
                op = ins_reg[31:28];
                case (op)
                    hdc_pkg::OPM_LOAD:  begin wr = 1'b1; nv = rdata_reg; end
                    hdc_pkg::OPM_STORE: ;
                    hdc_pkg::OPM_ADD:   begin wr = 1'b1; nv = b + rdata_reg; end
                    hdc_pkg::OPM_SUB:   begin wr = 1'b1; nv = b - rdata_reg; end
                    hdc_pkg::OPM_JUMP,
                    hdc_pkg::OPM_CALL:  begin jmp = 1'b1; jtgt = ea_reg; end
                    default:            bad = 1'b1;
                endcase
            end
            hdc_pkg::CL_IMM: begin
                op = ins_reg[27:24];
                wr = 1'b1;
                case (op)
                    hdc_pkg::OPI_MOV:  nv = v;
                    hdc_pkg::OPI_MOVS: nv = sv;
                    hdc_pkg::OPI_ADD:  nv = b + sv;
                    hdc_pkg::OPI_SUB:  nv = b - sv;
                    hdc_pkg::OPI_OR:   nv = b | v;
                    hdc_pkg::OPI_AND:  nv = b & v;
                    hdc_pkg::OPI_XOR:  nv = b ^ v;
                    default:           bad = 1'b1;
                endcase
            end
            hdc_pkg::CL_SHIFT: begin
                op = ins_reg[23:20];
                wr = 1'b1;
                case (op)
                    hdc_pkg::OPS_SLL,
                    hdc_pkg::OPS_SLA: nv = b << n;
                    hdc_pkg::OPS_SRL: nv = b >> n;
                    hdc_pkg::OPS_SRA: nv = 32'($signed(b) >>> n);
                    hdc_pkg::OPS_ROL: nv = rl[63:32];
                    hdc_pkg::OPS_ROR: nv = rr[31:0];
                    default:          bad = 1'b1;
                endcase
            end
            hdc_pkg::CL_REG: begin
                op = ins_reg[19:16];
                case (op)
                    hdc_pkg::OPR_MOV:  begin wr = 1'b1; nv = a_reg; end
                    hdc_pkg::OPR_ADD:  begin wr = 1'b1; nv = b + a_reg; end
                    hdc_pkg::OPR_SUB:  begin wr = 1'b1; nv = b - a_reg; end
                    hdc_pkg::OPR_OR:   begin wr = 1'b1; nv = a_reg | b; end
                    hdc_pkg::OPR_AND:  begin wr = 1'b1; nv = a_reg & b; end
                    hdc_pkg::OPR_XOR:  begin wr = 1'b1; nv = a_reg ^ b; end
                    hdc_pkg::OPR_SKGT: skip = $signed(b) < $signed(a_reg);
                    hdc_pkg::OPR_SKGE: skip = !($signed(a_reg) < $signed(b));
                    hdc_pkg::OPR_SKEQ: skip = (a_reg == b);
                    hdc_pkg::OPR_SKLE: skip = !($signed(b) < $signed(a_reg));
                    hdc_pkg::OPR_SKLT: skip = $signed(a_reg) < $signed(b);
                    hdc_pkg::OPR_OVF1,
                    hdc_pkg::OPR_OVF2: ;
                    default:           bad = 1'b1;
                endcase
            end
            hdc_pkg::CL_IO: begin
                op = ins_reg[11:8];
                case (op)
                    hdc_pkg::OPO_PUTC,
                    hdc_pkg::OPO_DUMP: ;
                    hdc_pkg::OPO_GETC: begin wr = 1'b1; nv = {a_reg[31:8], cur_reg.char_in}; end
                    default:           bad = 1'b1;
                endcase
            end
            hdc_pkg::CL_MISC: begin
                op = ins_reg[7:4];
                case (op)
                    hdc_pkg::OPX_NOP: ;
                    hdc_pkg::OPX_RET: begin jmp = 1'b1; jtgt = rdata_reg; end
                    default:          bad = 1'b1;
                endcase
            end
            default: ;
        endcase
        if (bad) begin
            stat = hdc_pkg::STAT_INVALID;
            wr   = 1'b0;
            jmp  = 1'b0;
        end
        base_pc = (wr && didx == hdc_pkg::PC_IDX) ? nv : pc;
    end

    // sequencer: control, memory ports and results
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        ins_next   = ins_reg;
        cls_next   = cls_reg;
        ea_next    = ea_reg;
        a_next     = a_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        raddr      = pc;
        mem_we     = 1'b0;
        waddr      = 32'd0;
        mem_wdata  = 32'd0;
        rf_we      = 1'b0;
        rf_idx     = q_item.reg_number;
        rf_val     = q_item.write_data;
        sp_set     = 1'b0;
        sp_val     = sp;
        pc_set     = 1'b0;
        pc_val     = pc;
        res_valid  = 1'b0;
        res        = '0;
        res.program_counter = pc;
        case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                waddr  = 32'(clr_reg);
                if (clr_reg == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.cmd)
                        hdc_pkg::CMD_STEP: begin
                            q_pop      = 1'b1;
                            cur_next   = q_item;
                            rd_en      = 1'b1;
                            state_next = S_DEC;
                        end
                        hdc_pkg::CMD_RD_MEM: begin
                            q_pop      = 1'b1;
                            rd_en      = 1'b1;
                            raddr      = addr_ext;
                            state_next = S_RDMEM;
                        end
                        hdc_pkg::CMD_WR_MEM: begin
                            if (out_free) begin
                                q_pop     = 1'b1;
                                mem_we    = 1'b1;
                                waddr     = addr_ext;
                                mem_wdata = q_item.write_data;
                                res_valid = 1'b1;
                            end
                        end
                        hdc_pkg::CMD_WR_REG: begin
                            if (out_free) begin
                                q_pop     = 1'b1;
                                rf_we     = 1'b1;
                                res_valid = 1'b1;
                                if (q_item.reg_number == hdc_pkg::PC_IDX)
                                    res.program_counter = q_item.write_data;
                            end
                        end
                        hdc_pkg::CMD_RD_REG: begin
                            if (out_free) begin
                                q_pop          = 1'b1;
                                res_valid      = 1'b1;
                                res.read_data  = rp_val;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                q_pop     = 1'b1;
                                res_valid = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DEC: begin
                // latch the instruction, form the address, start the data read
                ins_next = rdata_reg;
                cls_next = dcls;
                a_next   = rp_val;
                ea_next  = {12'd0, rdata_reg[19:0]} +
                           ((rdata_reg[27:24] != 4'd0) ? rp_val : 32'd0);
                rd_en    = 1'b1;
                raddr    = (dcls == hdc_pkg::CL_MISC) ? sp : ea_next;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    res.status = stat;
                    if (stat == hdc_pkg::STAT_OK) begin
                        if (wr && didx != hdc_pkg::PC_IDX) begin
                            rf_we  = 1'b1;
                            rf_idx = didx;
                            rf_val = nv;
                        end
                        pc_set = 1'b1;
                        pc_val = jmp ? jtgt : (base_pc + 32'd1 + 32'(skip));
                        if (cls_reg == hdc_pkg::CL_MEM && op == hdc_pkg::OPM_STORE) begin
                            mem_we    = 1'b1;
                            waddr     = ea_reg;
                            mem_wdata = b;
                        end
                        if (cls_reg == hdc_pkg::CL_MEM && op == hdc_pkg::OPM_CALL) begin
                            sp_set    = 1'b1;
                            sp_val    = sp - 32'd1;
                            mem_we    = 1'b1;
                            waddr     = sp_val;
                            mem_wdata = pc + 32'd1;
                        end
                        if (cls_reg == hdc_pkg::CL_MISC && op == hdc_pkg::OPX_RET) begin
                            sp_set = 1'b1;
                            sp_val = sp + 32'd1;
                        end
                        if (cls_reg == hdc_pkg::CL_IO) begin
                            case (op)
                                hdc_pkg::OPO_PUTC: begin
                                    res.char_out_valid = 1'b1;
                                    res.char_out       = a_reg[7:0];
                                end
                                hdc_pkg::OPO_GETC: res.char_in_taken = 1'b1;
                                hdc_pkg::OPO_DUMP: begin
                                    res.dump_valid = 1'b1;
                                    res.dump_reg   = ins_reg[3:0];
                                    res.read_data  = a_reg;
                                end
                                default: ;
                            endcase
                        end
                        res.program_counter = pc_val;
                    end
                end
            end
            S_RDMEM: begin
                if (out_free) begin
                    res_valid     = 1'b1;
                    res.read_data = rdata_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state, register file and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < 16; i++) regs_reg[i] <= 32'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (rf_we)  regs_reg[rf_idx]          <= rf_val;
            if (sp_set) regs_reg[hdc_pkg::SP_IDX] <= sp_val;
            if (pc_set) regs_reg[hdc_pkg::PC_IDX] <= pc_val;
        end
    end

    // item context, no reset needed
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        ins_reg <= ins_next;
        cls_reg <= cls_next;
        ea_reg  <= ea_next;
        a_reg   <= a_next;
    end

    // main memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr[AW-1:0]] <= mem_wdata;
        if (rd_en)  rdata_reg <= mem[raddr[AW-1:0]];
    end

endmodule
